/* rtl/tmt_pkg.sv */
// ----------------------------------------------------------------------------
// tmt_pkg
// Types and constants shared by the timed marker table and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package tmt_pkg;

  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned DUR_BITS    = 16;
  localparam int unsigned FLAG_BITS   = 8;
  localparam int unsigned SLOT_BITS   = 4;
  localparam int unsigned ACNT_BITS   = 5;
  localparam int unsigned CFG_BITS    = 16;
  localparam int unsigned CFG_IDX_BITS = 1;

  localparam logic [DUR_BITS-1:0]  MAX_DUR_RESET  = 16'd30000;
  localparam logic [FLAG_BITS-1:0] REMEMBER_RESET = 8'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DURATION  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_REMEMBER_MASK = 1'b1;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SWEEP  = 2'd1,
    FUNC_RECALL = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    STAT_STORED  = 3'd0,
    STAT_BAD_DUR = 3'd1,
    STAT_MOVED   = 3'd2,
    STAT_HELD    = 3'd3,
    STAT_IGNORED = 3'd4,
    STAT_SWEPT   = 3'd5,
    STAT_CLEARED = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_WRITE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]                   func;
    logic [TIME_BITS-1:0]         now;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic [DUR_BITS-1:0]          duration_ms;
    logic [FLAG_BITS-1:0]         marker_flags;
    logic                         key_repeat;
    logic                         input_allowed;
  } tmt_in_t;

  typedef struct packed {
    logic [2:0]                   status;
    logic [SLOT_BITS-1:0]         slot;
    logic signed [COORD_BITS-1:0] recall_x;
    logic signed [COORD_BITS-1:0] recall_y;
    logic [ACNT_BITS-1:0]         active_count;
  } tmt_out_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] t_start;
    logic [TIME_BITS-1:0] t_end;
  } slot_time_t;

  typedef struct packed {
    logic push;
    logic step;
    logic clear;
  } recall_cmd_t;

endpackage

`default_nettype wire

/* rtl/timed_marker_table_oldest_evict.sv */
// ----------------------------------------------------------------------------
// timed_marker_table_oldest_evict
// Timed marker table with oldest-entry replacement and a recall list.
// Handles one item at a time; the input stalls until the table is idle again.
// The scan reads one slot per cycle from the time memory through one shared
// 32-bit add/subtract unit.
// Reset clears the table, recall list and count and loads the register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_marker_table_oldest_evict #(
  parameter int unsigned SLOTS        = 16,
  parameter int unsigned RECENT_DEPTH = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  tmt_pkg::tmt_in_t                      in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output tmt_pkg::tmt_out_t                     out_item_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [tmt_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [tmt_pkg::CFG_BITS-1:0]     cfg_wdata_i
);
  import tmt_pkg::*;

  localparam int unsigned IW   = $clog2(SLOTS);
  localparam int unsigned CNTW = $clog2(SLOTS + 1);

  state_e state_q, state_d;
  tmt_in_t in_q;

  logic [DUR_BITS-1:0]  max_dur_q;
  logic [FLAG_BITS-1:0] mask_q;

  logic [SLOTS-1:0] active_q;
  logic [CNTW-1:0]  cnt_q;

  logic [IW:0]          addr_q;
  logic                 cmp_vld_q;
  logic [IW-1:0]        cmp_idx_q;
  logic [IW-1:0]        best_idx_q;
  logic [TIME_BITS-1:0] best_age_q;
  logic [IW-1:0]        pick_q;
  logic                 pick_new_q;

  status_e                      res_status_q, res_status_d;
  logic [SLOT_BITS-1:0]         res_slot_q;
  logic signed [COORD_BITS-1:0] res_x_q, res_y_q, res_x_d, res_y_d;

  logic     out_valid_q;
  tmt_out_t out_q;

  // Datapath
  slot_time_t           rd_data, wr_data;
  logic [TIME_BITS-1:0] alu_b, alu_y;
  logic                 alu_add;
  logic                 rd_issue, in_accept, out_free;
  logic                 is_insert, dur_bad, remember, cmp_active, cmp_last, age_ge;

  // Control strobes
  logic        scan_init, res_load, best_upd, pick_load, sweep_clr;
  logic        mem_we, act_set, clr_all, out_load;
  recall_cmd_t rcmd;
  logic        rec_empty;
  logic signed [COORD_BITS-1:0] rec_x, rec_y;

  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign is_insert  = (func_e'(in_q.func) == FUNC_INSERT);
  assign dur_bad    = (in_q.duration_ms == '0) || (in_q.duration_ms > max_dur_q);
  assign remember   = |(in_q.marker_flags & mask_q);
  assign cmp_active = active_q[cmp_idx_q];
  assign cmp_last   = (cmp_idx_q == IW'(SLOTS - 1));
  assign rd_issue   = (state_q == S_SCAN) && (addr_q < (IW + 1)'(SLOTS));

  // Shared time unit: age and expiry distance by subtract, end time by add
  assign alu_add = (state_q == S_WRITE);
  always_comb begin
    if (alu_add) begin
      alu_b = TIME_BITS'(in_q.duration_ms);
    end else if (is_insert) begin
      alu_b = rd_data.t_start;
    end else begin
      alu_b = rd_data.t_end;
    end
  end
  assign alu_y  = alu_add ? (in_q.now + alu_b) : (in_q.now - alu_b);
  assign age_ge = (alu_y >= best_age_q);

  assign wr_data.t_start = in_q.now;
  assign wr_data.t_end   = alu_y;

  tmt_slot_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pick_q),
    .wdata_i (wr_data),
    .raddr_i (addr_q[IW-1:0]),
    .rdata_o (rd_data)
  );

  tmt_recall #(
    .DEPTH (RECENT_DEPTH)
  ) u_recall (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (rcmd),
    .push_x_i (in_q.pos_x),
    .push_y_i (in_q.pos_y),
    .empty_o  (rec_empty),
    .rd_x_o   (rec_x),
    .rd_y_o   (rec_y)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (func_e'(in_q.func))
          FUNC_INSERT: state_d = dur_bad ? S_RESP : S_SCAN;
          FUNC_SWEEP:  state_d = S_SCAN;
          default:     state_d = S_RESP;
        endcase
      end
      S_SCAN: begin
        if (cmp_vld_q) begin
          if (is_insert) begin
            if (!cmp_active || cmp_last) state_d = S_WRITE;
          end else if (cmp_last) begin
            state_d = S_RESP;
          end
        end
      end
      S_WRITE: state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    scan_init    = 1'b0;
    res_load     = 1'b0;
    res_status_d = STAT_STORED;
    res_x_d      = '0;
    res_y_d      = '0;
    best_upd     = 1'b0;
    pick_load    = 1'b0;
    sweep_clr    = 1'b0;
    mem_we       = 1'b0;
    act_set      = 1'b0;
    clr_all      = 1'b0;
    out_load     = 1'b0;
    rcmd         = '0;
    case (state_q)
      S_DECODE: begin
        scan_init = 1'b1;
        res_load  = 1'b1;
        case (func_e'(in_q.func))
          FUNC_INSERT: res_status_d = dur_bad ? STAT_BAD_DUR : STAT_STORED;
          FUNC_SWEEP:  res_status_d = STAT_SWEPT;
          FUNC_RECALL: begin
            if (rec_empty || !in_q.input_allowed) begin
              res_status_d = STAT_IGNORED;
            end else if (in_q.key_repeat) begin
              res_status_d = STAT_HELD;
            end else begin
              res_status_d = STAT_MOVED;
              res_x_d      = rec_x;
              res_y_d      = rec_y;
              rcmd.step    = 1'b1;
            end
          end
          default: begin
            res_status_d = STAT_CLEARED;
            clr_all      = 1'b1;
            rcmd.clear   = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        if (cmp_vld_q) begin
          if (is_insert) begin
            best_upd  = cmp_active && age_ge;
            pick_load = !cmp_active || cmp_last;
          end else begin
            // Retire when the end is not in the future
            sweep_clr = cmp_active && !alu_y[TIME_BITS-1];
          end
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        act_set   = 1'b1;
        rcmd.push = remember;
      end
      S_RESP: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_dur_q   <= MAX_DUR_RESET;
      mask_q      <= REMEMBER_RESET;
      active_q    <= '0;
      cnt_q       <= '0;
      addr_q      <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_DURATION:  max_dur_q <= cfg_wdata_i;
          REG_REMEMBER_MASK: mask_q    <= cfg_wdata_i[FLAG_BITS-1:0];
          default: ;
        endcase
      end
      if (clr_all) begin
        active_q <= '0;
        cnt_q    <= '0;
      end else if (sweep_clr) begin
        active_q[cmp_idx_q] <= 1'b0;
        cnt_q               <= cnt_q - CNTW'(1);
      end else if (act_set) begin
        active_q[pick_q] <= 1'b1;
        if (pick_new_q) cnt_q <= cnt_q + CNTW'(1);
      end
      if (scan_init) begin
        addr_q <= '0;
      end else if (rd_issue) begin
        addr_q <= addr_q + (IW + 1)'(1);
      end
      cmp_vld_q <= rd_issue;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) in_q <= in_item_i;
    cmp_idx_q <= addr_q[IW-1:0];
    if (scan_init) begin
      best_idx_q <= '0;
      best_age_q <= '0;
    end else if (best_upd) begin
      best_idx_q <= cmp_idx_q;
      best_age_q <= alu_y;
    end
    if (pick_load) begin
      pick_q     <= (!cmp_active || age_ge) ? cmp_idx_q : best_idx_q;
      pick_new_q <= !cmp_active;
    end
    if (res_load) begin
      res_status_q <= res_status_d;
      res_slot_q   <= '0;
      res_x_q      <= res_x_d;
      res_y_q      <= res_y_d;
    end else if (act_set) begin
      res_slot_q <= SLOT_BITS'(pick_q);
    end
    if (out_load) begin
      out_q.status       <= res_status_q;
      out_q.slot         <= res_slot_q;
      out_q.recall_x     <= res_x_q;
      out_q.recall_y     <= res_y_q;
      out_q.active_count <= ACNT_BITS'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* rtl/tmt_slot_mem.sv */
// ----------------------------------------------------------------------------
// tmt_slot_mem
// Start and end times of every slot: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tmt_slot_mem #(
  parameter  int unsigned SLOTS = 16,
  localparam int unsigned IW    = $clog2(SLOTS)
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [IW-1:0]      waddr_i,
  input  tmt_pkg::slot_time_t     wdata_i,
  input  wire logic [IW-1:0]      raddr_i,
  output tmt_pkg::slot_time_t     rdata_o
);
  import tmt_pkg::*;

  slot_time_t mem [SLOTS];
  slot_time_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/tmt_recall.sv */
// ----------------------------------------------------------------------------
// tmt_recall
// Newest-first recall list of marker positions with a wrapping read cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module tmt_recall #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  tmt_pkg::recall_cmd_t                     cmd_i,
  input  wire logic signed [tmt_pkg::COORD_BITS-1:0] push_x_i,
  input  wire logic signed [tmt_pkg::COORD_BITS-1:0] push_y_i,
  output logic                                     empty_o,
  output logic signed [tmt_pkg::COORD_BITS-1:0]    rd_x_o,
  output logic signed [tmt_pkg::COORD_BITS-1:0]    rd_y_o
);
  import tmt_pkg::*;

  localparam int unsigned CW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic signed [COORD_BITS-1:0] x_q [DEPTH];
  logic signed [COORD_BITS-1:0] y_q [DEPTH];
  logic [NW-1:0] count_q, count_d;
  logic [CW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] cur;
  logic [NW-1:0] cur_inc;

  // Cursor past the count restarts at the newest entry
  assign cur     = (NW'(cursor_q) >= count_q) ? '0 : cursor_q;
  assign cur_inc = NW'(cur) + NW'(1);

  assign empty_o = (count_q == '0);
  assign rd_x_o  = x_q[cur];
  assign rd_y_o  = y_q[cur];

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    if (cmd_i.clear) begin
      count_d  = '0;
      cursor_d = '0;
    end else if (cmd_i.push) begin
      if (count_q != NW'(DEPTH)) begin
        count_d = count_q + NW'(1);
      end
      cursor_d = '0;
    end else if (cmd_i.step) begin
      cursor_d = (cur_inc >= count_q) ? '0 : CW'(cur_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
    end
  end

  // Shift line: newest at index 0, oldest falls off the end
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !cmd_i.clear) begin
      x_q[0] <= push_x_i;
      y_q[0] <= push_y_i;
      for (int i = 1; i < DEPTH; i++) begin
        x_q[i] <= x_q[i-1];
        y_q[i] <= y_q[i-1];
      end
    end
  end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed marker table. A queue of marker requests
// (directed cases, then random sequences across several register settings)
// feeds a bursty driver; a monitor with its own stall pattern compares every
// reply field against an in-bench model of the table and recall list.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tmt_pkg::*;

  localparam int unsigned NSLOT  = 16;
  localparam int unsigned NKEEP  = 8;
  localparam int unsigned NPHASE = 6;
  localparam logic [7:0] STALL_PATTERN = 8'b1100_1010;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  tmt_in_t  in_item_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  tmt_out_t out_item_o;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i   = '0;
  logic [CFG_BITS-1:0]     cfg_wdata_i = '0;

  timed_marker_table_oldest_evict #(
    .SLOTS        (NSLOT),
    .RECENT_DEPTH (NKEEP)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Table model
  logic [DUR_BITS-1:0]          max_dur;
  logic [FLAG_BITS-1:0]         keep_mask;
  bit                           slot_on [NSLOT];
  logic [TIME_BITS-1:0]         slot_t0 [NSLOT];
  logic [TIME_BITS-1:0]         slot_t1 [NSLOT];
  logic signed [COORD_BITS-1:0] keep_x  [NKEEP];
  logic signed [COORD_BITS-1:0] keep_y  [NKEEP];
  int unsigned                  keep_count;
  int unsigned                  keep_cursor;

  tmt_in_t  marker_requests[$];
  tmt_out_t predicted_replies[$];

  int unsigned error_count = 0;
  int unsigned burst_left  = 1;
  int unsigned gap_left    = 0;
  int unsigned stall_cycle = 0;
  int unsigned stall_run   = 0;

  function automatic void clear_marker_table();
    for (int i = 0; i < NSLOT; i++) begin
      slot_on[i] = 1'b0;
      slot_t0[i] = '0;
      slot_t1[i] = '0;
    end
    for (int i = 0; i < NKEEP; i++) begin
      keep_x[i] = '0;
      keep_y[i] = '0;
    end
    keep_count  = 0;
    keep_cursor = 0;
  endfunction

  function automatic void apply_marker_request(tmt_in_t it);
    tmt_out_t             r;
    int unsigned          pick;
    int unsigned          oldest;
    int unsigned          live;
    logic [TIME_BITS-1:0] age;
    logic [TIME_BITS-1:0] peak_age;
    logic [TIME_BITS-1:0] diff;
    r = '0;
    case (it.func)
      FUNC_INSERT: begin
        if (it.duration_ms == 0 || it.duration_ms > max_dur) begin
          r.status = STAT_BAD_DUR;
        end else begin
          pick = NSLOT;
          oldest = 0;
          peak_age = '0;
          for (int i = 0; i < NSLOT; i++) begin
            if (!slot_on[i]) begin
              pick = i;
              break;
            end
            // ties go to the later slot
            age = it.now - slot_t0[i];
            if (age >= peak_age) begin
              oldest = i;
              peak_age = age;
            end
          end
          if (pick == NSLOT) pick = oldest;
          slot_on[pick] = 1'b1;
          slot_t0[pick] = it.now;
          slot_t1[pick] = it.now + TIME_BITS'(it.duration_ms);
          if ((it.marker_flags & keep_mask) != 0) begin
            // push newest first, drop the oldest when full
            for (int i = NKEEP - 1; i > 0; i--) begin
              keep_x[i] = keep_x[i-1];
              keep_y[i] = keep_y[i-1];
            end
            keep_x[0] = it.pos_x;
            keep_y[0] = it.pos_y;
            keep_count  = (keep_count + 1 < NKEEP) ? keep_count + 1 : NKEEP;
            keep_cursor = 0;
          end
          r.status = STAT_STORED;
          r.slot   = SLOT_BITS'(pick);
        end
      end
      FUNC_SWEEP: begin
        for (int i = 0; i < NSLOT; i++) begin
          diff = it.now - slot_t1[i];
          if (slot_on[i] && !diff[TIME_BITS-1]) slot_on[i] = 1'b0;
        end
        r.status = STAT_SWEPT;
      end
      FUNC_RECALL: begin
        if (keep_count == 0 || !it.input_allowed) begin
          r.status = STAT_IGNORED;
        end else if (it.key_repeat) begin
          r.status = STAT_HELD;
        end else begin
          if (keep_cursor >= keep_count) keep_cursor = 0;
          r.recall_x = keep_x[keep_cursor];
          r.recall_y = keep_y[keep_cursor];
          keep_cursor++;
          if (keep_cursor >= keep_count) keep_cursor = 0;
          r.status = STAT_MOVED;
        end
      end
      default: begin
        clear_marker_table();
        r.status = STAT_CLEARED;
      end
    endcase
    live = 0;
    for (int i = 0; i < NSLOT; i++) live += slot_on[i] ? 1 : 0;
    r.active_count = ACNT_BITS'(live);
    predicted_replies.push_back(r);
  endfunction

  // Random request; duration leans toward the accepted range with edges mixed in
  function automatic tmt_in_t random_marker(func_e f, logic [TIME_BITS-1:0] t);
    tmt_in_t it;
    it.func          = f;
    it.now           = t;
    it.pos_x         = COORD_BITS'($urandom);
    it.pos_y         = COORD_BITS'($urandom);
    it.marker_flags  = FLAG_BITS'($urandom);
    it.key_repeat    = ($urandom_range(0, 4) == 0);
    it.input_allowed = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 9))
      0:       it.duration_ms = '0;
      1:       it.duration_ms = max_dur;
      2:       it.duration_ms = max_dur + 16'd1;
      3:       it.duration_ms = DUR_BITS'($urandom);
      default: it.duration_ms = (max_dur == 0) ? 16'd1 : DUR_BITS'($urandom_range(1, max_dur));
    endcase
    return it;
  endfunction

  task automatic queue_marker(func_e f, logic [TIME_BITS-1:0] t,
                              logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
                              logic [DUR_BITS-1:0] d, logic [FLAG_BITS-1:0] fl,
                              logic rep, logic ok);
    tmt_in_t it;
    it.func = f;
    it.now = t;
    it.pos_x = x;
    it.pos_y = y;
    it.duration_ms = d;
    it.marker_flags = fl;
    it.key_repeat = rep;
    it.input_allowed = ok;
    marker_requests.push_back(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic wait_until_drained();
    do @(negedge clk_i);
    while (marker_requests.size() != 0 || in_valid_i || predicted_replies.size() != 0);
  endtask

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) flag_error($sformatf("mismatch in %s: expected %0h, got %0h", name, want, got));
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) apply_marker_request(in_item_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0 || marker_requests.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          in_item_i  <= marker_requests.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // Receiver: compare replies, stall in four modes that rotate in turn
  always @(posedge clk_i) begin : reply_monitor
    tmt_out_t want;
    logic     stall_next;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_replies.size() == 0) begin
        flag_error($sformatf("reply %0h arrived with none outstanding", out_item_o));
      end else begin
        want = predicted_replies.pop_front();
        check_field("status", 32'(want.status), 32'(out_item_o.status));
        check_field("slot", 32'(want.slot), 32'(out_item_o.slot));
        check_field("recall_x", 32'(want.recall_x), 32'(out_item_o.recall_x));
        check_field("recall_y", 32'(want.recall_y), 32'(out_item_o.recall_y));
        check_field("active_count", 32'(want.active_count), 32'(out_item_o.active_count));
      end
    end
    case ((stall_cycle >> 8) % 4)
      0: stall_next = 1'b0;
      1: stall_next = ($urandom_range(0, 2) == 0);
      2: begin
        if (stall_run > 0) begin
          stall_run--;
          stall_next = 1'b1;
        end else begin
          if ($urandom_range(0, 15) == 0) stall_run = $urandom_range(1, 24);
          stall_next = 1'b0;
        end
      end
      default: stall_next = STALL_PATTERN[stall_cycle % 8];
    endcase
    stall_cycle++;
    out_stall_i <= stall_next;
  end

  initial begin : stimulus
    logic [DUR_BITS-1:0]  phase_max   [NPHASE];
    logic [FLAG_BITS-1:0] phase_mask  [NPHASE];
    int unsigned          phase_items [NPHASE];
    logic [TIME_BITS-1:0] gen_now;
    tmt_in_t              it;
    int unsigned          made;
    int unsigned          n;
    int unsigned          roll;
    func_e                f;

    phase_max   = '{16'd30000, 16'd1, 16'd65535, 16'd0, 16'd65535, 16'd2000};
    phase_mask  = '{8'h01, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h5A};
    phase_items = '{200, 230, 230, 40, 330, 300};

    max_dur   = MAX_DUR_RESET;
    keep_mask = REMEMBER_RESET;
    clear_marker_table();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    gen_now = 32'hFFFF_0000;
    for (int p = 0; p < NPHASE; p++) begin
      if (p > 0) begin
        wait_until_drained();
        write_reg(REG_MAX_DURATION, phase_max[p]);
        write_reg(REG_REMEMBER_MASK, CFG_BITS'(phase_mask[p]));
        @(posedge clk_i);
        cfg_we_i  <= 1'b0;
        max_dur   = phase_max[p];
        keep_mask = phase_mask[p];
      end else begin
        queue_marker(FUNC_RECALL, 32'd0, 16'sd0, 16'sd0, 16'd0, 8'h00, 1'b0, 1'b1);
        queue_marker(FUNC_INSERT, 32'd5, 16'sd1, 16'sd1, 16'd0, 8'h01, 1'b0, 1'b1);
        queue_marker(FUNC_INSERT, 32'd5, 16'sd1, 16'sd1, 16'd30001, 8'h01, 1'b0, 1'b1);
        queue_marker(FUNC_INSERT, 32'd0, 16'sh7FFF, 16'sh8000, 16'd30000, 8'h01, 1'b0, 1'b1);
        // end time wraps past zero
        queue_marker(FUNC_INSERT, 32'hFFFF_FFF0, 16'sh8000, 16'sh7FFF, 16'h0020, 8'hFE,
                     1'b1, 1'b0);
        queue_marker(FUNC_INSERT, 32'd100, 16'sd1, -16'sd1, 16'd500, 8'hFF, 1'b0, 1'b1);
        queue_marker(FUNC_RECALL, 32'd110, 16'sd0, 16'sd0, 16'd0, 8'h00, 1'b0, 1'b0);
        queue_marker(FUNC_RECALL, 32'd110, 16'sd0, 16'sd0, 16'd0, 8'h00, 1'b1, 1'b1);
        repeat (3) queue_marker(FUNC_RECALL, 32'd120, 16'sd0, 16'sd0, 16'd0, 8'h00, 1'b0, 1'b1);
        // sweep exactly at an end time, then exactly at another
        queue_marker(FUNC_SWEEP, 32'h0000_0010, 16'sd0, 16'sd0, 16'd0, 8'h00, 1'b0, 1'b1);
        queue_marker(FUNC_SWEEP, 32'd30000, 16'sd0, 16'sd0, 16'd0, 8'h00, 1'b0, 1'b1);
        // overflow the recall list
        for (int k = 0; k < 9; k++)
          queue_marker(FUNC_INSERT, 32'd40000 + k, COORD_BITS'(k * 1000), COORD_BITS'(-k),
                       DUR_BITS'(1000 + k), 8'h81, 1'b0, 1'b1);
        repeat (2) queue_marker(FUNC_RECALL, 32'd41000, 16'sd0, 16'sd0, 16'd0, 8'h00, 1'b0, 1'b1);
        queue_marker(FUNC_CLEAR, 32'd41000, 16'sd0, 16'sd0, 16'd0, 8'h00, 1'b0, 1'b1);
        queue_marker(FUNC_RECALL, 32'd41000, 16'sd0, 16'sd0, 16'd0, 8'h00, 1'b0, 1'b1);
      end

      made = 0;
      while (made < phase_items[p]) begin
        if ($urandom_range(0, 39) == 0) gen_now = $urandom;
        else gen_now += $urandom_range(0, max_dur / 4 + 8);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            roll = $urandom_range(0, 99);
            f = (roll < 50) ? FUNC_INSERT : (roll < 65) ? FUNC_SWEEP :
                (roll < 97) ? FUNC_RECALL : FUNC_CLEAR;
            marker_requests.push_back(random_marker(f, gen_now));
            made++;
          end
          5, 6: begin
            // inserts at one time: can fill the table and ties the ages
            n = $urandom_range(8, 20);
            repeat (n) begin
              it = random_marker(FUNC_INSERT, gen_now);
              if (max_dur != 0 && $urandom_range(0, 5) != 0)
                it.duration_ms = DUR_BITS'($urandom_range(1, max_dur));
              marker_requests.push_back(it);
            end
            made += n;
          end
          7, 8: begin
            n = $urandom_range(3, 12);
            repeat (n) marker_requests.push_back(random_marker(FUNC_RECALL, gen_now));
            made += n;
          end
          default: begin
            gen_now += $urandom_range(0, 2 * max_dur + 2);
            marker_requests.push_back(random_marker(FUNC_SWEEP, gen_now));
            made++;
          end
        endcase
      end
    end

    wait_until_drained();
    repeat (NSLOT + 8) @(posedge clk_i);
    if (error_count == 0 && predicted_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(15_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
